[src/iabk_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
package iabk_pkg;

    localparam int DATA_WIDTH_DEF = 32;
    localparam int CFG_WIDTH = 31;
    localparam int CFG_IDX_WIDTH = 3;
    localparam int FRAC = 28;
    localparam int ACC_WIDTH = 25;
    localparam int GYRO_WIDTH = 28;
    localparam int WIDE = 82;

    localparam logic [CFG_IDX_WIDTH-1:0] REG_Q_ANGLE = 3'd0;
    localparam logic [CFG_IDX_WIDTH-1:0] REG_Q_BIAS = 3'd1;
    localparam logic [CFG_IDX_WIDTH-1:0] REG_R_ANGLE = 3'd2;
    localparam logic [CFG_IDX_WIDTH-1:0] REG_Q_ACCEL = 3'd3;
    localparam logic [CFG_IDX_WIDTH-1:0] REG_R_ACCEL = 3'd4;
    localparam logic [CFG_IDX_WIDTH-1:0] REG_Q_GYRO = 3'd5;
    localparam logic [CFG_IDX_WIDTH-1:0] REG_R_GYRO = 3'd6;
    localparam logic [CFG_IDX_WIDTH-1:0] REG_PERIOD = 3'd7;

    localparam logic signed [31:0] COV_SMALL = 32'sd53687091;
    localparam logic signed [31:0] COV_BIG = 32'sd590558003;

    localparam logic signed [WIDE-1:0] S32_MAX = WIDE'(64'sd2147483647);
    localparam logic signed [WIDE-1:0] S32_MIN = WIDE'(-64'sd2147483648);

    typedef enum logic [1:0] {
        OP_MUL,
        OP_DIV
    } op_t;

    typedef struct packed {
        logic start;
        op_t op;
    } unit_cmd_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_ISSUE,
        S_WAIT,
        S_OUT
    } state_t;

    function automatic logic signed [WIDE-1:0] sat32w(input logic signed [WIDE-1:0] x);
        if (x > S32_MAX)
            return S32_MAX;
        else if (x < S32_MIN)
            return S32_MIN;
        return x;
    endfunction

endpackage
`default_nettype wire

[src/iabk_unit.sv]
`timescale 1ns / 1ps
`default_nettype none
module iabk_unit (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire iabk_pkg::unit_cmd_t                 cmd,
    input  wire logic signed [iabk_pkg::WIDE-1:0]    a,
    input  wire logic signed [iabk_pkg::WIDE-1:0]    b,
    output logic                                     done,
    output logic signed [iabk_pkg::WIDE-1:0]         result
);
    localparam int W = iabk_pkg::WIDE;
    localparam logic signed [W-1:0] ROUND = W'(64'sd1 <<< (iabk_pkg::FRAC - 1));

    logic busy_reg, busy_next;
    iabk_pkg::op_t op_reg, op_next;
    logic [6:0] cnt_reg, cnt_next;
    logic neg_reg, neg_next;
    logic [W-1:0] rem_reg, rem_next;
    logic [W-1:0] den_reg, den_next;
    logic [W-1:0] quo_reg, quo_next;
    logic signed [W-1:0] acc_reg, acc_next;
    logic signed [W-1:0] mand_reg, mand_next;
    logic [31:0] mier_reg, mier_next;
    logic [W-1:0] trial;
    logic [W-1:0] shifted;
    logic signed [W-1:0] fin;

    always_comb
    begin
        busy_next = busy_reg;
        op_next = op_reg;
        cnt_next = cnt_reg;
        neg_next = neg_reg;
        rem_next = rem_reg;
        den_next = den_reg;
        quo_next = quo_reg;
        acc_next = acc_reg;
        mand_next = mand_reg;
        mier_next = mier_reg;
        done = 1'b0;
        shifted = {rem_reg[W-2:0], quo_reg[W-1]};
        trial = shifted - den_reg;
        if (!busy_reg)
        begin
            if (cmd.start)
            begin
                busy_next = 1'b1;
                op_next = cmd.op;
                acc_next = '0;
                rem_next = '0;
                if (cmd.op == iabk_pkg::OP_MUL)
                begin
                    // walk the 32-bit two's complement factor b, sign bit last
                    mand_next = a;
                    mier_next = b[31:0];
                    cnt_next = 7'd32;
                end
                else
                begin
                    neg_next = a[W-1];
                    quo_next = (a[W-1] ? -a : a) << iabk_pkg::FRAC;
                    den_next = b;
                    cnt_next = 7'(W);
                end
            end
        end
        else if (op_reg == iabk_pkg::OP_MUL)
        begin
            if (cnt_reg != 0)
            begin
                if (mier_reg[0])
                    acc_next = (cnt_reg == 7'd1) ? acc_reg - mand_reg : acc_reg + mand_reg;
                mand_next = mand_reg <<< 1;
                mier_next = mier_reg >> 1;
                cnt_next = cnt_reg - 7'd1;
            end
            else
            begin
                done = 1'b1;
                busy_next = 1'b0;
            end
        end
        else
        begin
            if (cnt_reg != 0)
            begin
                if (!trial[W-1])
                begin
                    rem_next = trial;
                    quo_next = {quo_reg[W-2:0], 1'b1};
                end
                else
                begin
                    rem_next = shifted;
                    quo_next = {quo_reg[W-2:0], 1'b0};
                end
                cnt_next = cnt_reg - 7'd1;
            end
            else
            begin
                done = 1'b1;
                busy_next = 1'b0;
            end
        end
        if (op_reg == iabk_pkg::OP_MUL)
            fin = (acc_reg + ROUND) >>> iabk_pkg::FRAC;
        else
            fin = neg_reg ? -$signed(quo_reg) : $signed(quo_reg);
    end

    assign result = fin;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            op_reg <= iabk_pkg::OP_MUL;
            cnt_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            op_reg <= op_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        neg_reg <= neg_next;
        rem_reg <= rem_next;
        den_reg <= den_next;
        quo_reg <= quo_next;
        acc_reg <= acc_next;
        mand_reg <= mand_next;
        mier_reg <= mier_next;
    end
endmodule
`default_nettype wire

[src/imu_angle_bias_kalman_top.sv]
`timescale 1ns / 1ps
`default_nettype none
// Operation: 18 operations per input word on one shared serial unit, 14 products
//   and 4 quotients, run one after another.
// Flow: one word at a time, no new word is taken; in_stall stays high until the result is taken.
// Reset: asynchronous active low; registers take their defaults, filter
//   state takes its documented reset values.
module imu_angle_bias_kalman_top #(
    parameter int DATA_WIDTH = iabk_pkg::DATA_WIDTH_DEF
) (
    input  wire logic                                   clk,
    input  wire logic                                   rst_n,
    input  wire logic                                   cfg_we,
    input  wire logic [iabk_pkg::CFG_IDX_WIDTH-1:0]     cfg_index,
    input  wire logic [iabk_pkg::CFG_WIDTH-1:0]         cfg_data,
    input  wire logic                                   in_valid,
    output logic                                        in_stall,
    input  wire logic signed [iabk_pkg::ACC_WIDTH-1:0]  accel_angle,
    input  wire logic signed [iabk_pkg::GYRO_WIDTH-1:0] gyro_rate,
    output logic                                        out_valid,
    input  wire logic                                   out_stall,
    output logic signed [31:0]                          angle
);
    localparam int W = iabk_pkg::WIDE;
    localparam logic signed [W-1:0] DMAX = (W'(1) <<< (DATA_WIDTH - 1)) - W'(1);
    localparam logic signed [W-1:0] DMIN = -(W'(1) <<< (DATA_WIDTH - 1));

    logic [30:0] cfg_reg [8];
    iabk_pkg::state_t st_reg, st_next;
    logic [4:0] step_reg, step_next;
    logic signed [W-1:0] v_reg [24];
    logic signed [W-1:0] v_next [24];
    logic signed [W-1:0] ua, ub, ures;
    logic udone;
    logic use_div;
    logic skip;
    iabk_pkg::unit_cmd_t cmd;
    logic signed [31:0] angle_reg;

    // variable slots
    localparam int AE = 0, AC = 1, GE = 2, GC = 3, AP = 4, BP = 5;
    localparam int P00 = 6, P01 = 7, P10 = 8, P11 = 9;
    localparam int SA = 10, SG = 11, K = 12, T = 13, K0 = 14, K1 = 15;
    localparam int ANG = 16, BIA = 17, C00 = 18, C01 = 19, C10 = 20, C11 = 21, DT = 22, M = 23;

    function automatic logic signed [W-1:0] satd(input logic signed [W-1:0] x);
        if (x > DMAX)
            return DMAX;
        else if (x < DMIN)
            return DMIN;
        return x;
    endfunction

    function automatic logic signed [W-1:0] cv(input logic [30:0] x);
        return W'(x);
    endfunction

    // operand selection per step
    always_comb
    begin
        ua = '0;
        ub = '0;
        use_div = 1'b0;
        skip = 1'b0;
        case (step_reg)
            5'd0:
            begin
                ua = v_reg[AC];
                ub = v_reg[AC] + cv(cfg_reg[iabk_pkg::REG_R_ACCEL]);
                use_div = 1'b1;
                skip = ub <= 0;
            end
            5'd1:
            begin
                ua = v_reg[SA] - v_reg[AE];
                ub = v_reg[K];
            end
            5'd2:
            begin
                ua = v_reg[AC];
                ub = v_reg[K];
            end
            5'd3:
            begin
                ua = v_reg[GC];
                ub = v_reg[GC] + cv(cfg_reg[iabk_pkg::REG_R_GYRO]);
                use_div = 1'b1;
                skip = ub <= 0;
            end
            5'd4:
            begin
                ua = v_reg[SG] - v_reg[GE];
                ub = v_reg[K];
            end
            5'd5:
            begin
                ua = v_reg[GC];
                ub = v_reg[K];
            end
            5'd6:
            begin
                ua = v_reg[P00];
                ub = v_reg[P00] + cv(cfg_reg[iabk_pkg::REG_R_ANGLE]);
                use_div = 1'b1;
                skip = ub <= 0;
            end
            5'd7:
            begin
                ua = v_reg[P10];
                ub = v_reg[P00] + cv(cfg_reg[iabk_pkg::REG_R_ANGLE]);
                use_div = 1'b1;
                skip = ub <= 0;
            end
            5'd8:
            begin
                ua = v_reg[SA] - v_reg[AP];
                ub = v_reg[K0];
            end
            5'd9:
            begin
                ua = v_reg[SA] - v_reg[AP];
                ub = v_reg[K1];
            end
            5'd10:
            begin
                ua = v_reg[P00];
                ub = v_reg[K0];
            end
            5'd11:
            begin
                ua = v_reg[P01];
                ub = v_reg[K0];
            end
            5'd12:
            begin
                ua = v_reg[P00];
                ub = v_reg[K1];
            end
            5'd13:
            begin
                ua = v_reg[P01];
                ub = v_reg[K1];
            end
            5'd14:
            begin
                ua = v_reg[C11];
                ub = v_reg[DT];
            end
            5'd15:
            begin
                ua = v_reg[SG] - v_reg[BIA];
                ub = v_reg[DT];
            end
            5'd16:
            begin
                ua = v_reg[M] - v_reg[C01] - v_reg[C10] + cv(cfg_reg[iabk_pkg::REG_Q_ANGLE]);
                ub = v_reg[DT];
            end
            5'd17:
            begin
                ua = cv(cfg_reg[iabk_pkg::REG_Q_BIAS]);
                ub = v_reg[DT];
            end
            default:
            begin
                ua = '0;
                ub = '0;
            end
        endcase
    end

    // result write-back
    always_comb
    begin
        logic signed [W-1:0] r;
        r = ures;
        for (int i = 0; i < 24; i++)
            v_next[i] = v_reg[i];
        if (use_div)
            r = skip ? '0 : iabk_pkg::sat32w(ures);
        case (step_reg)
            5'd0: v_next[K] = r;
            5'd1: v_next[AE] = satd(v_reg[AE] + r);
            5'd2:
            begin
                v_next[SA] = satd(v_reg[AE]);
                v_next[AC] = iabk_pkg::sat32w(
                    iabk_pkg::sat32w(v_reg[AC] - r) + cv(cfg_reg[iabk_pkg::REG_Q_ACCEL]));
            end
            5'd3: v_next[K] = r;
            5'd4: v_next[GE] = satd(v_reg[GE] + r);
            5'd5:
            begin
                v_next[SG] = v_reg[GE];
                v_next[GC] = iabk_pkg::sat32w(
                    iabk_pkg::sat32w(v_reg[GC] - r) + cv(cfg_reg[iabk_pkg::REG_Q_GYRO]));
            end
            5'd6: v_next[K0] = r;
            5'd7: v_next[K1] = r;
            5'd8: v_next[ANG] = satd(v_reg[AP] + r);
            5'd9: v_next[BIA] = satd(v_reg[BP] + r);
            5'd10: v_next[C00] = iabk_pkg::sat32w(v_reg[P00] - r);
            5'd11: v_next[C01] = iabk_pkg::sat32w(v_reg[P01] - r);
            5'd12: v_next[C10] = iabk_pkg::sat32w(v_reg[P10] - r);
            5'd13: v_next[C11] = iabk_pkg::sat32w(v_reg[P11] - r);
            5'd14:
            begin
                v_next[M] = r;
                v_next[P01] = iabk_pkg::sat32w(v_reg[C01] - r);
                v_next[P10] = iabk_pkg::sat32w(v_reg[C10] - r);
            end
            5'd15:
            begin
                v_next[AP] = satd(v_reg[ANG] + r);
                v_next[BP] = v_reg[BIA];
            end
            5'd16: v_next[P00] = iabk_pkg::sat32w(v_reg[C00] + r);
            5'd17: v_next[P11] = iabk_pkg::sat32w(v_reg[C11] + r);
            default: v_next[T] = v_reg[T];
        endcase
    end

    // next state
    always_comb
    begin
        st_next = st_reg;
        step_next = step_reg;
        case (st_reg)
            iabk_pkg::S_IDLE:
                if (in_valid)
                    st_next = iabk_pkg::S_ISSUE;
            iabk_pkg::S_ISSUE: st_next = iabk_pkg::S_WAIT;
            iabk_pkg::S_WAIT:
                if (udone)
                begin
                    if (step_reg == 5'd17)
                    begin
                        st_next = iabk_pkg::S_OUT;
                        step_next = '0;
                    end
                    else
                    begin
                        st_next = iabk_pkg::S_ISSUE;
                        step_next = step_reg + 5'd1;
                    end
                end
            iabk_pkg::S_OUT:
                if (!out_stall)
                    st_next = iabk_pkg::S_IDLE;
            default: st_next = iabk_pkg::S_IDLE;
        endcase
    end

    // outputs
    always_comb
    begin
        in_stall = st_reg != iabk_pkg::S_IDLE;
        out_valid = st_reg == iabk_pkg::S_OUT;
        cmd.start = st_reg == iabk_pkg::S_ISSUE;
        cmd.op = use_div ? iabk_pkg::OP_DIV : iabk_pkg::OP_MUL;
    end

    assign angle = angle_reg;

    iabk_unit u_unit (
        .clk    (clk),
        .rst_n  (rst_n),
        .cmd    (cmd),
        .a      (ua),
        .b      (ub),
        .done   (udone),
        .result (ures)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg <= iabk_pkg::S_IDLE;
            step_reg <= '0;
            cfg_reg[iabk_pkg::REG_Q_ANGLE] <= 31'd268435;
            cfg_reg[iabk_pkg::REG_Q_BIAS] <= 31'd805306;
            cfg_reg[iabk_pkg::REG_R_ANGLE] <= 31'd8026220;
            cfg_reg[iabk_pkg::REG_Q_ACCEL] <= 31'd26844;
            cfg_reg[iabk_pkg::REG_R_ACCEL] <= 31'd8026220;
            cfg_reg[iabk_pkg::REG_Q_GYRO] <= 31'd268435;
            cfg_reg[iabk_pkg::REG_R_GYRO] <= 31'd35352950;
            cfg_reg[iabk_pkg::REG_PERIOD] <= 31'd2684355;
            for (int i = 0; i < 24; i++)
                v_reg[i] <= (i == AC || i == GC) ? W'(iabk_pkg::COV_SMALL) :
                            (i == P00 || i == P11) ? W'(iabk_pkg::COV_BIG) : '0;
            angle_reg <= '0;
        end
        else
        begin
            st_reg <= st_next;
            step_reg <= step_next;
            if (cfg_we)
            begin
                if (cfg_index == iabk_pkg::REG_PERIOD)
                    cfg_reg[cfg_index] <= {2'b00, cfg_data[28:0]};
                else
                    cfg_reg[cfg_index] <= cfg_data;
            end
            if (st_reg == iabk_pkg::S_IDLE && in_valid)
            begin
                v_reg[SA] <= W'(accel_angle);
                v_reg[SG] <= W'(gyro_rate);
                v_reg[DT] <= cv(cfg_reg[iabk_pkg::REG_PERIOD]);
            end
            else if (st_reg == iabk_pkg::S_WAIT && udone)
            begin
                for (int i = 0; i < 24; i++)
                    v_reg[i] <= v_next[i];
                if (step_reg == 5'd8)
                    angle_reg <= 32'(iabk_pkg::sat32w(v_next[ANG]));
            end
        end
    end
endmodule
`default_nettype wire
